FILE: rtl/gdfs_pkg.sv
// Shared constants and controller/datapath interface types for the graph DFS engine.
package gdfs_pkg;

   localparam int NODES      = 64;
   localparam int ARCS       = 256;
   localparam int STACK_CAP  = ARCS + 1;
   localparam int NODE_W     = $clog2(NODES);
   localparam int ARC_W      = $clog2(ARCS);
   localparam int CNT_W      = $clog2(ARCS + 1);
   localparam int DEPTH_W    = $clog2(STACK_CAP + 1);
   localparam int SADDR_W    = $clog2(STACK_CAP);

   // operation codes
   localparam logic [1:0] OP_EDGE   = 2'd0;
   localparam logic [1:0] OP_ARC    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic latch_req;    // capture node_a/node_b
      logic arc_swap;     // source is node_b for the second arc of an edge
      logic arc_rd;       // read last arc of source node
      logic arc_wr;       // link new arc
      logic set_ovf;      // arc dropped
      logic search_init;  // push start node
      logic pop_rd;       // pop top of stack
      logic visit_rd;     // mark popped node, read its node tables
      logic visit_take;   // queue visit result, load arc cursor
      logic tgt_rd;       // read arc target and link
      logic tgt_chk;      // push target if unvisited, advance cursor
      logic emit_flush;   // send held result as the last one
      logic emit_nf;      // send not-found result
   } gdfs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic start_seen;
      logic depth_zero;
      logic node_seen;
      logic node_has;
      logic at_last;
      logic pend_valid;
      logic rsp_free;
   } gdfs_sts_type;

endpackage

FILE: rtl/gdfs_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
module gdfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/gdfs_datapath.sv
// Datapath: adjacency lists, visit marks, walk stack and result register.
module gdfs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  gdfs_pkg::gdfs_cmd_type        cmd,
   output gdfs_pkg::gdfs_sts_type        sts,
   input  logic [gdfs_pkg::NODE_W-1:0]   in_a,
   input  logic [gdfs_pkg::NODE_W-1:0]   in_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gdfs_pkg::NODE_W-1:0]   rsp_node,
   output logic [gdfs_pkg::NODE_W-1:0]   rsp_parent,
   output logic                          rsp_root,
   output logic                          rsp_found,
   output logic                          rsp_ovf,
   output logic                          rsp_last
);

   localparam int NW = gdfs_pkg::NODE_W;
   localparam int AW = gdfs_pkg::ARC_W;

   logic [NW-1:0] a_ff, b_ff, start_ff, node_ff;
   logic [AW-1:0] cur_ff, last_ff;
   logic [gdfs_pkg::DEPTH_W-1:0] depth_ff;
   logic [gdfs_pkg::CNT_W-1:0]   count_ff;
   logic ovf_ff;
   logic [gdfs_pkg::NODES-1:0] visited_ff, has_ff;
   logic [NW-1:0] pend_node_ff, pend_par_ff;
   logic pend_root_ff, pend_valid_ff;
   logic rsp_valid_ff;
   logic [NW-1:0] rsp_node_ff, rsp_par_ff;
   logic rsp_root_ff, rsp_found_ff, rsp_ovf_ff, rsp_last_ff;

   logic [NW-1:0] src, dst;
   logic [AW-1:0] slot;
   logic [NW-1:0] stack_rdata, tgt_rdata, par_rdata;
   logic [AW-1:0] first_rdata, last_rdata, next_rdata;
   logic [NW-1:0] node_raddr;
   logic          stack_we, tgt_push;
   logic [gdfs_pkg::SADDR_W-1:0] stack_waddr, stack_raddr;
   logic [NW-1:0] stack_wdata;
   logic          rsp_free, is_root;

   assign src  = cmd.arc_swap ? b_ff : a_ff;
   assign dst  = cmd.arc_swap ? a_ff : b_ff;
   assign slot = count_ff[AW-1:0];
   assign node_raddr = cmd.visit_rd ? stack_rdata : src;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign is_root  = (node_ff == start_ff);

   // push of an unvisited target while scanning arcs
   assign tgt_push = cmd.tgt_chk && !visited_ff[tgt_rdata]
                     && (depth_ff < gdfs_pkg::DEPTH_W'(gdfs_pkg::STACK_CAP));
   assign stack_we    = cmd.search_init || tgt_push;
   assign stack_waddr = cmd.search_init ? '0 : depth_ff[gdfs_pkg::SADDR_W-1:0];
   assign stack_wdata = cmd.search_init ? a_ff : tgt_rdata;
   assign stack_raddr = gdfs_pkg::SADDR_W'(depth_ff - 1'b1);

   // adjacency, parent and stack memories
   gdfs_ram #(.WIDTH(AW), .DEPTH(gdfs_pkg::NODES)) u_first (
      .clock(clock), .we(cmd.arc_wr && !has_ff[src]), .waddr(src), .wdata(slot),
      .re(cmd.visit_rd), .raddr(node_raddr), .rdata(first_rdata));
   gdfs_ram #(.WIDTH(AW), .DEPTH(gdfs_pkg::NODES)) u_last (
      .clock(clock), .we(cmd.arc_wr), .waddr(src), .wdata(slot),
      .re(cmd.visit_rd || cmd.arc_rd), .raddr(node_raddr), .rdata(last_rdata));
   gdfs_ram #(.WIDTH(NW), .DEPTH(gdfs_pkg::ARCS)) u_target (
      .clock(clock), .we(cmd.arc_wr), .waddr(slot), .wdata(dst),
      .re(cmd.tgt_rd), .raddr(cur_ff), .rdata(tgt_rdata));
   gdfs_ram #(.WIDTH(AW), .DEPTH(gdfs_pkg::ARCS)) u_next (
      .clock(clock), .we(cmd.arc_wr && has_ff[src]), .waddr(last_rdata), .wdata(slot),
      .re(cmd.tgt_rd), .raddr(cur_ff), .rdata(next_rdata));
   gdfs_ram #(.WIDTH(NW), .DEPTH(gdfs_pkg::NODES)) u_parent (
      .clock(clock), .we(tgt_push), .waddr(tgt_rdata), .wdata(node_ff),
      .re(cmd.visit_rd), .raddr(node_raddr), .rdata(par_rdata));
   gdfs_ram #(.WIDTH(NW), .DEPTH(gdfs_pkg::STACK_CAP)) u_stack (
      .clock(clock), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
      .re(cmd.pop_rd), .raddr(stack_raddr), .rdata(stack_rdata));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         visited_ff    <= '0;
         has_ff        <= '0;
         depth_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.set_ovf) ovf_ff <= 1'b1;
         if (cmd.arc_wr) begin
            count_ff    <= count_ff + 1'b1;
            has_ff[src] <= 1'b1;
         end
         if (cmd.visit_rd) visited_ff[stack_rdata] <= 1'b1;
         if (cmd.search_init) depth_ff <= gdfs_pkg::DEPTH_W'(1);
         else if (cmd.pop_rd) depth_ff <= depth_ff - 1'b1;
         else if (tgt_push) depth_ff <= depth_ff + 1'b1;
         if (cmd.visit_take) pend_valid_ff <= 1'b1;
         else if (cmd.emit_flush) pend_valid_ff <= 1'b0;
         if ((cmd.visit_take && pend_valid_ff) || cmd.emit_flush || cmd.emit_nf) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         a_ff <= in_a;
         b_ff <= in_b;
      end
      if (cmd.search_init) start_ff <= a_ff;
      if (cmd.pop_rd) node_ff <= node_ff;
      if (cmd.visit_rd) node_ff <= stack_rdata;
      if (cmd.visit_take) begin
         cur_ff       <= first_rdata;
         last_ff      <= last_rdata;
         pend_node_ff <= node_ff;
         pend_par_ff  <= is_root ? '0 : par_rdata;
         pend_root_ff <= is_root;
      end
      if (cmd.tgt_chk) cur_ff <= next_rdata;
      if ((cmd.visit_take && pend_valid_ff) || cmd.emit_flush) begin
         rsp_node_ff  <= pend_node_ff;
         rsp_par_ff   <= pend_par_ff;
         rsp_root_ff  <= pend_root_ff;
         rsp_found_ff <= 1'b1;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= cmd.emit_flush;
      end else if (cmd.emit_nf) begin
         rsp_node_ff  <= '0;
         rsp_par_ff   <= '0;
         rsp_root_ff  <= 1'b0;
         rsp_found_ff <= 1'b0;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= 1'b1;
      end
   end

   // status to controller
   always_comb begin
      sts.full       = (count_ff == gdfs_pkg::CNT_W'(gdfs_pkg::ARCS));
      sts.start_seen = visited_ff[a_ff];
      sts.depth_zero = (depth_ff == '0);
      sts.node_seen  = visited_ff[stack_rdata];
      sts.node_has   = has_ff[node_ff];
      sts.at_last    = (cur_ff == last_ff);
      sts.pend_valid = pend_valid_ff;
      sts.rsp_free   = rsp_free;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_parent = rsp_par_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_ovf    = rsp_ovf_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

FILE: rtl/gdfs_ctrl.sv
// Controller: sequences arc inserts and the stack-driven search.
module gdfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   output gdfs_pkg::gdfs_cmd_type cmd,
   input  gdfs_pkg::gdfs_sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_ARC_TRY, S_ARC_WR, S_POP, S_POP_WAIT,
      S_VISIT, S_TGT_RD, S_TGT_CHK, S_FLUSH, S_NOTFOUND
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       swap_ff, swap_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      swap_in  = swap_ff;
      cmd      = '0;
      cmd.arc_swap = swap_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               op_in    = req_op;
               swap_in  = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (op_ff == gdfs_pkg::OP_EDGE || op_ff == gdfs_pkg::OP_ARC) begin
               state_in = S_ARC_TRY;
            end else if (op_ff == gdfs_pkg::OP_SEARCH) begin
               if (sts.start_seen) begin
                  state_in = S_NOTFOUND;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in = S_POP;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ARC_TRY: begin
            if (sts.full) begin
               cmd.set_ovf = 1'b1;
               if (op_ff == gdfs_pkg::OP_EDGE && !swap_ff) begin
                  swap_in = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.arc_rd = 1'b1;
               state_in = S_ARC_WR;
            end
         end
         S_ARC_WR: begin
            cmd.arc_wr = 1'b1;
            if (op_ff == gdfs_pkg::OP_EDGE && !swap_ff) begin
               swap_in  = 1'b1;
               state_in = S_ARC_TRY;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            if (sts.depth_zero) begin
               state_in = S_FLUSH;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            if (sts.node_seen) begin
               state_in = S_POP;
            end else begin
               cmd.visit_rd = 1'b1;
               state_in = S_VISIT;
            end
         end
         S_VISIT: begin
            if (!sts.pend_valid || sts.rsp_free) begin
               cmd.visit_take = 1'b1;
               state_in = sts.node_has ? S_TGT_RD : S_POP;
            end
         end
         S_TGT_RD: begin
            cmd.tgt_rd = 1'b1;
            state_in = S_TGT_CHK;
         end
         S_TGT_CHK: begin
            cmd.tgt_chk = 1'b1;
            state_in = sts.at_last ? S_POP : S_TGT_RD;
         end
         S_FLUSH: begin
            if (sts.rsp_free) begin
               cmd.emit_flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_NOTFOUND: begin
            if (sts.rsp_free) begin
               cmd.emit_nf = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= gdfs_pkg::OP_EDGE;
         swap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         swap_ff  <= swap_in;
      end
   end

endmodule

FILE: rtl/graph_dfs_engine.sv
// Top level of the graph DFS engine: stream ports, controller and datapath.
//
//  channel | direction | transaction
//  req_    | in        | one graph op: add edge, add arc or start search
//  rsp_    | out       | one visited node per transaction, tlast on the final one
//
// An arc insert reads the source's last arc, then links the new arc; an edge
// inserts both arcs. A search pops the stack, skips visited entries, visits new
// nodes and scans their arcs via registered reads of the stack and arc memories.
// A new request is taken only once the previous one is finished; rsp_tready
// low stalls the walk at the next result.
// Reset is synchronous and needs no clearing pass.
module graph_dfs_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // op[1:0], node_a[7:2], node_b[13:8], zero[15:14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // visited_node[5:0], parent_node[11:6], is_root[12],
                                   // edge_overflow[13], zero[15:14]
   output logic        rsp_tuser,  // found[0]
   output logic        rsp_tlast
);

   gdfs_pkg::gdfs_cmd_type cmd;
   gdfs_pkg::gdfs_sts_type sts;
   logic [gdfs_pkg::NODE_W-1:0] rsp_node, rsp_parent;
   logic rsp_root, rsp_ovf;

   gdfs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready), .req_op(req_tdata[1:0]),
      .cmd(cmd), .sts(sts));

   gdfs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_a(req_tdata[7:2]), .in_b(req_tdata[13:8]),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_node(rsp_node), .rsp_parent(rsp_parent), .rsp_root(rsp_root),
      .rsp_found(rsp_tuser), .rsp_ovf(rsp_ovf), .rsp_last(rsp_tlast));

   assign rsp_tdata = {2'b00, rsp_ovf, rsp_root, rsp_parent, rsp_node};

endmodule

FILE: tb/tb_graph_dfs_engine.sv
// Testbench for the graph DFS engine: random graph builds and searches checked by a predictor.
module tb_graph_dfs_engine;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;

   // one expected visit transaction
   typedef struct packed {
      logic [5:0] visited_node;
      logic [5:0] parent_node;
      logic       is_root;
      logic       found;
      logic       edge_overflow;
      logic       last;
   } visit_type;

   // graph predictor plus store of expected visits
   class dfs_scoreboard;
      logic [7:0] first_arc[gdfs_pkg::NODES];
      logic [7:0] last_arc[gdfs_pkg::NODES];
      bit         has_arcs[gdfs_pkg::NODES];
      logic [5:0] arc_target[gdfs_pkg::ARCS];
      logic [7:0] arc_next[gdfs_pkg::ARCS];
      int         arc_count;
      bit         visited[gdfs_pkg::NODES];
      logic [5:0] parent_of[gdfs_pkg::NODES];
      bit         overflow;
      visit_type  pending_visits[$];
      int         errors;

      function new();
         arc_count = 0;
         overflow  = 0;
         errors    = 0;
         for (int i = 0; i < gdfs_pkg::NODES; i++) begin
            has_arcs[i]  = 0;
            visited[i]   = 0;
            parent_of[i] = '0;
         end
      endfunction

      function void link_arc(int src, int dst);
         if (arc_count >= gdfs_pkg::ARCS) begin
            overflow = 1;
            return;
         end
         arc_target[arc_count] = dst[5:0];
         if (has_arcs[src]) arc_next[last_arc[src]] = arc_count[7:0];
         else begin
            first_arc[src] = arc_count[7:0];
            has_arcs[src]  = 1;
         end
         last_arc[src] = arc_count[7:0];
         arc_count++;
      endfunction

      // walk the graph from the start node and queue the visit order
      function void walk_from(int start);
         int        node_stack[$];
         int        node;
         int        a;
         visit_type v;
         bit        any;
         any = 0;
         if (visited[start]) begin
            v = '0;
            v.edge_overflow = overflow;
            v.last = 1;
            pending_visits.push_back(v);
            return;
         end
         node_stack.push_back(start);
         while (node_stack.size() != 0) begin
            node = node_stack.pop_back();
            if (visited[node]) continue;
            visited[node] = 1;
            v.visited_node  = node[5:0];
            v.is_root       = (node == start);
            v.parent_node   = v.is_root ? 6'd0 : parent_of[node];
            v.found         = 1;
            v.edge_overflow = overflow;
            v.last          = 0;
            pending_visits.push_back(v);
            any = 1;
            if (!has_arcs[node]) continue;
            a = first_arc[node];
            forever begin
               if (!visited[arc_target[a]]) begin
                  parent_of[arc_target[a]] = node[5:0];
                  node_stack.push_back(arc_target[a]);
               end
               if (a == last_arc[node]) break;
               a = arc_next[a];
            end
         end
         if (any) pending_visits[$].last = 1;
      endfunction

      function void note_request(logic [1:0] op, logic [5:0] na, logic [5:0] nb);
         case (op)
            gdfs_pkg::OP_EDGE: begin
               link_arc(na, nb);
               link_arc(nb, na);
            end
            gdfs_pkg::OP_ARC:    link_arc(na, nb);
            gdfs_pkg::OP_SEARCH: walk_from(na);
            default: ;
         endcase
      endfunction

      function void check_visit(visit_type got);
         visit_type exp;
         if (pending_visits.size() == 0) begin
            $error("unexpected visit transaction %h", got);
            errors++;
            return;
         end
         exp = pending_visits.pop_front();
         if (got.visited_node !== exp.visited_node) begin
            $error("visited_node exp %0d got %0d", exp.visited_node, got.visited_node);
            errors++;
         end
         if (got.parent_node !== exp.parent_node) begin
            $error("parent_node exp %0d got %0d", exp.parent_node, got.parent_node);
            errors++;
         end
         if (got.is_root !== exp.is_root) begin
            $error("is_root exp %0b got %0b", exp.is_root, got.is_root);
            errors++;
         end
         if (got.found !== exp.found) begin
            $error("found exp %0b got %0b", exp.found, got.found);
            errors++;
         end
         if (got.edge_overflow !== exp.edge_overflow) begin
            $error("edge_overflow exp %0b got %0b", exp.edge_overflow, got.edge_overflow);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last exp %0b got %0b", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   dfs_scoreboard sb;
   bit            calm = 0;
   int            cycles = 0;

   graph_dfs_engine u_top (.*);

   always #5 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, check each accepted transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_visit({rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[12], rsp_tuser,
                         rsp_tdata[13], rsp_tlast});
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_tready <= 1;
         if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            @(posedge clock);
            rsp_tready <= 0;
            repeat (gap - 1) @(posedge clock);
         end
      end
   end

   // valid stays high between back-to-back transactions; drops only for idle gaps
   task automatic send_request(logic [1:0] op, logic [5:0] na, logic [5:0] nb);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {2'b00, nb, na, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, na, nb);
   endtask

   task automatic random_request(int n_nodes);
      int r;
      r = $urandom_range(0, 19);
      if (r < 9)
         send_request(gdfs_pkg::OP_EDGE, 6'($urandom_range(0, n_nodes - 1)),
                      6'($urandom_range(0, n_nodes - 1)));
      else if (r < 14)
         send_request(gdfs_pkg::OP_ARC, 6'($urandom_range(0, n_nodes - 1)),
                      6'($urandom_range(0, n_nodes - 1)));
      else if (r < 19)
         send_request(gdfs_pkg::OP_SEARCH, 6'($urandom_range(0, 63)), 6'($urandom()));
      else
         send_request(OP_NONE, 6'($urandom()), 6'($urandom()));
   endtask

   initial begin
      int wait_cycles;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, self loop, directed arc, repeat search, unused op
      send_request(gdfs_pkg::OP_EDGE, 6'd0, 6'd63);
      send_request(gdfs_pkg::OP_ARC, 6'd63, 6'd42);
      send_request(gdfs_pkg::OP_ARC, 6'd21, 6'd0);
      send_request(gdfs_pkg::OP_EDGE, 6'd42, 6'd42);
      send_request(gdfs_pkg::OP_EDGE, 6'd0, 6'd21);
      send_request(OP_NONE, 6'd63, 6'd63);
      send_request(gdfs_pkg::OP_SEARCH, 6'd63, 6'd63);
      send_request(gdfs_pkg::OP_SEARCH, 6'd0, 6'd0);
      send_request(gdfs_pkg::OP_SEARCH, 6'd5, 6'd0);
      send_request(gdfs_pkg::OP_SEARCH, 6'd5, 6'd0);

      // random: dense graph on few nodes, then the full node range
      for (int i = 0; i < 120; i++) random_request(12);
      for (int i = 0; i < 80; i++) random_request(64);

      // fill arc storage past capacity, then search with overflow seen
      while (sb.arc_count < gdfs_pkg::ARCS)
         send_request(gdfs_pkg::OP_EDGE, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
      send_request(gdfs_pkg::OP_ARC, 6'd1, 6'd2);
      calm = 1;
      for (int i = 0; i < 30; i++) random_request(64);
      for (int i = 0; i < 64; i++) send_request(gdfs_pkg::OP_SEARCH, i[5:0], 6'd0);
      req_tvalid <= 0;

      wait_cycles = 0;
      while (sb.pending_visits.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_visits.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
